/* sv/rws_pkg.sv */
// Shared types and constants for the resampling wheel selector.
package rws_pkg;

    localparam int NUM_SLOTS_DEF   = 32;
    localparam int WEIGHT_BITS_DEF = 16;

    // Fixed field widths of the transaction payloads.
    localparam int SLOT_FIELD_W   = 5;
    localparam int WEIGHT_FIELD_W = 16;
    localparam int FRAC_W         = 16;

    // Request codes.
    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_BEGIN = 2'd1;
    localparam logic [1:0] REQ_DRAW  = 2'd2;

    typedef struct packed {
        logic [1:0]                req_type;
        logic [SLOT_FIELD_W-1:0]   slot;
        logic [WEIGHT_FIELD_W-1:0] weight_value;
        logic [FRAC_W-1:0]         random_fraction;
    } req_t;

    typedef struct packed {
        logic [SLOT_FIELD_W-1:0] chosen_index;
        logic                    walk_capped;
    } rsp_t;

endpackage

/* sv/rws_weight_mem.sv */
// Weight storage: one write port and one read port with registered read data.
module rws_weight_mem
    import rws_pkg::*;
#(
    parameter int NUM_SLOTS   = NUM_SLOTS_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
    localparam int SLOT_W     = $clog2(NUM_SLOTS)
)
(
    input  logic                   clk,
    input  logic                   we,
    input  logic [SLOT_W-1:0]      waddr,
    input  logic [WEIGHT_BITS-1:0] wdata,
    input  logic [SLOT_W-1:0]      raddr,
    output logic [WEIGHT_BITS-1:0] rdata
);

    logic [WEIGHT_BITS-1:0] mem [NUM_SLOTS];
    logic [WEIGHT_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/resampling_wheel_selector.sv */
// Resampling wheel selector: picks particle slots from loaded weights.
// Load: writes a weight and tracks the largest. Begin: reduces the start slot modulo the
// slot count. Draw: S_MUL, S_ADD, then k walk steps (k <= 3*NUM_SLOTS), result registered;
// the walk advances one slot a cycle, bounded by the weight memory's single read port.
// Input stall is high while a begin or draw is being worked on.
// Reset clears control state, largest weight, cursor and beta; weights stay unwritten.
module resampling_wheel_selector
    import rws_pkg::*;
#(
    parameter int NUM_SLOTS   = NUM_SLOTS_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int SLOT_W     = $clog2(NUM_SLOTS);
    localparam int MW         = (SLOT_W + 1 > SLOT_FIELD_W) ? SLOT_W + 1 : SLOT_FIELD_W;
    localparam int BW         = WEIGHT_BITS + 2;
    localparam int PW         = FRAC_W + WEIGHT_BITS + 1;
    localparam int WALK_LIMIT = 3 * NUM_SLOTS;
    localparam int STEP_W     = $clog2(WALK_LIMIT + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_MUL,
        S_ADD,
        S_WALK
    } state_t;

    state_t                 state_reg;
    logic [WEIGHT_BITS-1:0] largest_reg;
    logic [SLOT_W-1:0]      cursor_reg;
    logic [BW-1:0]          beta_reg;
    logic [STEP_W-1:0]      step_reg;
    logic [MW-1:0]          mod_reg;
    logic [FRAC_W-1:0]      frac_reg;
    logic [PW-1:0]          prod_reg;
    logic                   rsp_valid_reg;
    rsp_t                   rsp_reg;

    logic                   accept;
    logic [MW-1:0]          slot_ext;
    logic                   slot_in_range;
    logic [WEIGHT_BITS-1:0] load_weight;
    logic                   mem_we;
    logic [SLOT_W-1:0]      raddr;
    logic [WEIGHT_BITS-1:0] rdata;
    logic [BW-1:0]          weight_ext;
    logic                   over;
    logic                   advance;
    logic                   rsp_free;
    logic                   emit;
    logic [SLOT_W-1:0]      cursor_inc;
    logic [BW:0]            beta_sum;
    logic [BW-1:0]          beta_sat;

    assign accept        = req_valid && !req_stall;
    assign req_stall     = (state_reg != S_IDLE);
    assign slot_ext      = MW'(req.slot);
    assign slot_in_range = (slot_ext < MW'(NUM_SLOTS));
    assign load_weight   = WEIGHT_BITS'(req.weight_value);
    assign mem_we        = accept && (req.req_type == REQ_LOAD) && slot_in_range;

    assign weight_ext = BW'(rdata);
    assign over       = (beta_reg > weight_ext);
    assign advance    = (state_reg == S_WALK) && over && (step_reg < STEP_W'(WALK_LIMIT));
    assign rsp_free   = !rsp_valid_reg || !rsp_stall;
    assign emit       = (state_reg == S_WALK) && !advance && rsp_free;
    assign cursor_inc = (cursor_reg == SLOT_W'(NUM_SLOTS - 1)) ? '0
                                                               : cursor_reg + SLOT_W'(1);
    // Keep the read port one step ahead so the registered data matches the cursor.
    assign raddr      = advance ? cursor_inc : cursor_reg;

    assign beta_sum = {1'b0, beta_reg} + (BW + 1)'(prod_reg[PW-1:FRAC_W]);
    assign beta_sat = beta_sum[BW] ? '1 : beta_sum[BW-1:0];

    rws_weight_mem #(
        .NUM_SLOTS   (NUM_SLOTS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_weight_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (slot_ext[SLOT_W-1:0]),
        .wdata (load_weight),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            largest_reg   <= '0;
            cursor_reg    <= '0;
            beta_reg      <= '0;
            step_reg      <= '0;
            mod_reg       <= '0;
            frac_reg      <= '0;
            prod_reg      <= '0;
            rsp_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= emit || (rsp_valid_reg && rsp_stall);
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        unique case (req.req_type)
                            REQ_LOAD:
                            begin
                                if (slot_in_range &&
                                    ((slot_ext == '0) || (load_weight > largest_reg)))
                                begin
                                    largest_reg <= load_weight;
                                end
                            end
                            REQ_BEGIN:
                            begin
                                mod_reg   <= slot_ext;
                                beta_reg  <= '0;
                                state_reg <= S_MOD;
                            end
                            REQ_DRAW:
                            begin
                                frac_reg  <= req.random_fraction;
                                state_reg <= S_MUL;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_MOD:
                begin
                    // Reduce the start slot modulo the slot count by repeated subtraction.
                    if (mod_reg >= MW'(NUM_SLOTS))
                    begin
                        mod_reg <= mod_reg - MW'(NUM_SLOTS);
                    end
                    else
                    begin
                        cursor_reg <= mod_reg[SLOT_W-1:0];
                        state_reg  <= S_IDLE;
                    end
                end
                S_MUL:
                begin
                    prod_reg  <= PW'(frac_reg * {largest_reg, 1'b0});
                    state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    beta_reg  <= beta_sat;
                    step_reg  <= '0;
                    state_reg <= S_WALK;
                end
                S_WALK:
                begin
                    if (advance)
                    begin
                        beta_reg   <= beta_reg - weight_ext;
                        cursor_reg <= cursor_inc;
                        step_reg   <= step_reg + STEP_W'(1);
                    end
                    else if (rsp_free)
                    begin
                        rsp_reg.chosen_index <= SLOT_FIELD_W'(cursor_reg);
                        rsp_reg.walk_capped  <= over;
                        state_reg            <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (step_reg <= STEP_W'(WALK_LIMIT)))
        else $error("walk step count passed the lap limit");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cursor_reg) < NUM_SLOTS)
        else $error("wheel cursor out of slot range");

    a_beta_positive: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (beta_reg != '0))
        else $error("beta reached zero after a walk step");

    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == S_WALK))
        else $error("result raised outside of a walk");

endmodule

/* verif/resampling_wheel_selector_tb.sv */
// Self-checking testbench for the resampling wheel selector with a scoreboard class.
module resampling_wheel_selector_tb;
    import rws_pkg::*;

    localparam int         WALK_STEPS   = 3 * NUM_SLOTS_DEF;
    localparam int         RANDOM_ITEMS = 1300;
    localparam logic [1:0] REQ_UNUSED   = 2'd3;

    class pick_scoreboard;
        bit [WEIGHT_FIELD_W-1:0] weight_mem [NUM_SLOTS_DEF];
        bit [WEIGHT_FIELD_W-1:0] max_weight;
        bit [SLOT_FIELD_W-1:0]   cursor;
        bit [WEIGHT_FIELD_W+1:0] beta;
        rsp_t                    expected_picks [$];
        int                      errors;

        function void note_request(req_t r);
            bit [FRAC_W+WEIGHT_FIELD_W:0] product;
            bit [WEIGHT_FIELD_W+2:0]      sum;
            int                           steps;
            rsp_t                         pick;
            case (r.req_type)
                REQ_LOAD:
                begin
                    weight_mem[r.slot] = r.weight_value;
                    if (r.slot == 0 || r.weight_value > max_weight)
                        max_weight = r.weight_value;
                end
                REQ_BEGIN:
                begin
                    cursor = r.slot;
                    beta   = '0;
                end
                REQ_DRAW:
                begin
                    product = r.random_fraction * {max_weight, 1'b0};
                    sum     = beta + product[FRAC_W +: WEIGHT_FIELD_W+1];
                    // The top bit of the sum marks an overflow; beta then saturates.
                    beta    = sum[WEIGHT_FIELD_W+2] ? '1 : sum[WEIGHT_FIELD_W+1:0];
                    steps   = 0;
                    while (steps < WALK_STEPS && beta > weight_mem[cursor])
                    begin
                        beta   = beta - weight_mem[cursor];
                        cursor = SLOT_FIELD_W'((int'(cursor) + 1) % NUM_SLOTS_DEF);
                        steps++;
                    end
                    pick.chosen_index = cursor;
                    pick.walk_capped  = beta > weight_mem[cursor];
                    expected_picks    = {expected_picks, pick};
                end
                default:
                    ;
            endcase
        endfunction

        function void check_result(rsp_t got);
            rsp_t want;
            if (expected_picks.size() == 0)
            begin
                $error("unexpected transaction: chosen_index %0d walk_capped %0b",
                       got.chosen_index, got.walk_capped);
                errors++;
                return;
            end
            want = expected_picks.pop_front();
            if (got.chosen_index !== want.chosen_index)
            begin
                $error("chosen_index: expected %0d, actual %0d",
                       want.chosen_index, got.chosen_index);
                errors++;
            end
            if (got.walk_capped !== want.walk_capped)
            begin
                $error("walk_capped: expected %0b, actual %0b",
                       want.walk_capped, got.walk_capped);
                errors++;
            end
        endfunction

        function int pending();
            return expected_picks.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;
    bit   calm;

    pick_scoreboard picks_sb = new();

    resampling_wheel_selector u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            picks_sb.check_result(rsp);
    end

    // The result side holds off in random bursts until the quiet tail of the run.
    initial
    begin
        int hold;
        rsp_stall = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 7) == 0)
            begin
                hold = $urandom_range(1, 13);
                rsp_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    function automatic req_t compose(logic [1:0] kind, logic [SLOT_FIELD_W-1:0] slot,
                                     logic [15:0] value);
        req_t r;
        r.req_type        = kind;
        r.slot            = slot;
        r.weight_value    = (kind == REQ_LOAD) ? value : WEIGHT_FIELD_W'($urandom);
        r.random_fraction = (kind == REQ_DRAW) ? value : FRAC_W'($urandom);
        return r;
    endfunction

    function automatic logic [15:0] pick_weight(int profile);
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default:
            begin
                if (profile == 0)
                    return 16'($urandom);
                else if (profile == 1)
                    return 16'($urandom_range(0, 255));
                else
                    return ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'h0000;
            end
        endcase
    endfunction

    function automatic logic [15:0] pick_fraction();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_req(input req_t r);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (req_stall);
        picks_sb.note_request(r);
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (picks_sb.pending() != 0);
    endtask

    initial
    begin
        int counted;
        int profile;
        int offset;
        int draws;
        req_valid = 1'b0;
        req       = '0;
        rst_n     = 1'b0;
        calm      = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every slot is written before the first draw: one full weight in slot 0.
        send_req(compose(REQ_LOAD, SLOT_FIELD_W'(0), 16'hFFFF));
        for (int s = 1; s < NUM_SLOTS_DEF; s++)
            send_req(compose(REQ_LOAD, SLOT_FIELD_W'(s), 16'h0000));

        send_req(compose(REQ_UNUSED, SLOT_FIELD_W'($urandom), 16'($urandom)));
        send_req(compose(REQ_BEGIN, SLOT_FIELD_W'(31), 16'h0));
        send_req(compose(REQ_DRAW, SLOT_FIELD_W'($urandom), 16'hFFFF));
        send_req(compose(REQ_DRAW, SLOT_FIELD_W'($urandom), 16'h0000));

        // A fresh set of all zeros whose largest weight stays at full scale:
        // each draw with a nonzero beta walks to the lap limit and beta runs into saturation.
        send_req(compose(REQ_LOAD, SLOT_FIELD_W'(0), 16'h0000));
        send_req(compose(REQ_LOAD, SLOT_FIELD_W'(9), 16'hFFFF));
        send_req(compose(REQ_LOAD, SLOT_FIELD_W'(9), 16'h0000));
        send_req(compose(REQ_BEGIN, SLOT_FIELD_W'(0), 16'h0));
        repeat (4) send_req(compose(REQ_DRAW, SLOT_FIELD_W'($urandom), 16'hFFFF));
        send_req(compose(REQ_DRAW, SLOT_FIELD_W'($urandom), 16'h0000));
        send_req(compose(REQ_BEGIN, SLOT_FIELD_W'(7), 16'h0));
        send_req(compose(REQ_DRAW, SLOT_FIELD_W'($urandom), 16'h0000));
        send_req(compose(REQ_DRAW, SLOT_FIELD_W'($urandom), 16'h0001));

        // Beta equal to the slot weight must not advance the cursor.
        send_req(compose(REQ_LOAD, SLOT_FIELD_W'(0), 16'h0001));
        send_req(compose(REQ_BEGIN, SLOT_FIELD_W'(0), 16'h0));
        send_req(compose(REQ_DRAW, SLOT_FIELD_W'($urandom), 16'hFFFF));
        send_req(compose(REQ_LOAD, SLOT_FIELD_W'(31), 16'h8000));
        send_req(compose(REQ_BEGIN, SLOT_FIELD_W'(30), 16'h0));
        send_req(compose(REQ_DRAW, SLOT_FIELD_W'($urandom), 16'hFFFF));
        wait_drained();

        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            if (counted >= RANDOM_ITEMS - 150)
                calm = 1'b1;
            if ($urandom_range(0, 99) < 15)
            begin
                profile = $urandom_range(0, 2);
                offset  = $urandom_range(0, NUM_SLOTS_DEF - 2);
                send_req(compose(REQ_LOAD, SLOT_FIELD_W'(0), pick_weight(profile)));
                for (int k = 0; k < NUM_SLOTS_DEF - 1; k++)
                    send_req(compose(REQ_LOAD,
                                     SLOT_FIELD_W'(1 + (k + offset) % (NUM_SLOTS_DEF - 1)),
                                     pick_weight(profile)));
                counted += NUM_SLOTS_DEF;
            end
            else
            begin
                repeat ($urandom_range(0, 4))
                begin
                    send_req(compose(REQ_LOAD, SLOT_FIELD_W'($urandom),
                                     pick_weight($urandom_range(0, 2))));
                    counted++;
                end
            end

            send_req(compose(REQ_BEGIN, SLOT_FIELD_W'($urandom), 16'h0));
            counted++;
            draws = $urandom_range(1, 12);
            repeat (draws)
            begin
                send_req(compose(REQ_DRAW, SLOT_FIELD_W'($urandom), pick_fraction()));
                counted++;
                if ($urandom_range(0, 14) == 0)
                    send_req(compose(REQ_UNUSED, SLOT_FIELD_W'($urandom), 16'($urandom)));
                if ($urandom_range(0, 24) == 0)
                begin
                    send_req(compose(REQ_BEGIN, SLOT_FIELD_W'($urandom), 16'h0));
                    counted++;
                end
            end
            if ($urandom_range(0, 29) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (WALK_STEPS + 20) @(posedge clk);
        if (picks_sb.errors == 0 && picks_sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* files.f */
sv/rws_pkg.sv
sv/rws_weight_mem.sv
sv/resampling_wheel_selector.sv
verif/resampling_wheel_selector_tb.sv
